@@ src/tlvp_pkg.sv @@
// Shared types, constants and helpers for the TLV record parser.
// Used by the top level, the result stage and the port checker.
`timescale 1ns / 1ps

package tlvp_pkg;

    // Escape codes of a header nibble.
    localparam int EscOne = 13;
    localparam int EscTwo = 14;

    localparam int ValWidth = 17;
    localparam logic [ValWidth-1:0] TwoByteBias = 17'h00100;

    // Parser phase.
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_TYPE_A = 3'd1,
        PH_TYPE_B = 3'd2,
        PH_LEN_A  = 3'd3,
        PH_LEN_B  = 3'd4,
        PH_VALUE  = 3'd5
    } phase_t;

    // Nibble class.
    typedef enum logic [1:0] {
        NC_LITERAL  = 2'd0,
        NC_ESC_ONE  = 2'd1,
        NC_ESC_TWO  = 2'd2,
        NC_RESERVED = 2'd3
    } nclass_t;

    // Result word kinds.
    typedef enum logic [1:0] {
        KIND_CONSUMED = 2'd0,
        KIND_DESC     = 2'd1,
        KIND_VALUE    = 2'd2,
        KIND_ERROR    = 2'd3
    } kind_t;

    // Error codes.
    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_INCOMPLETE = 2'd1,
        ERR_RESERVED   = 2'd2
    } err_t;

    // Action decided for one input word.
    typedef enum logic [2:0] {
        ACT_CONSUME  = 3'd0,
        ACT_DESC     = 3'd1,
        ACT_VALUE    = 3'd2,
        ACT_ERR_SHORT = 3'd3,
        ACT_ERR_RSVD = 3'd4
    } action_t;

    // One result word.
    typedef struct packed {
        kind_t                kind;
        logic [ValWidth-1:0]  record_type;
        logic [ValWidth-1:0]  record_length;
        logic [7:0]           value_byte;
        logic                 record_end;
        err_t                 error_code;
    } result_t;

    // Classify a header nibble; the one-byte escape wins if both codes match.
    function automatic nclass_t nibble_class(input logic [3:0] n);
        nclass_t c;
        if (n < 4'(EscOne)) begin
            c = NC_LITERAL;
        end else if (n == 4'(EscOne)) begin
            c = NC_ESC_ONE;
        end else if (n == 4'(EscTwo)) begin
            c = NC_ESC_TWO;
        end else begin
            c = NC_RESERVED;
        end
        return c;
    endfunction

endpackage

@@ src/tlvp_out_stage.sv @@
// Result register with valid/ready handshake for the TLV record parser.
// Depends on tlvp_pkg for the result word type.
`timescale 1ns / 1ps

module tlvp_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  tlvp_pkg::result_t load_word,
    output logic              can_load,
    output logic              m_valid,
    input  logic              m_ready,
    output tlvp_pkg::result_t m_word
);
    import tlvp_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t word_reg;

    // The register may take a new word when empty or when its word leaves now.
    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= load_word;
        end
    end

    assign m_valid = valid_reg;
    assign m_word  = word_reg;

endmodule

@@ src/tlv_record_parser_unit.sv @@
// Top level of the TLV record parser: header decode, extension assembly,
// value pass-through. Depends on tlvp_pkg and tlvp_out_stage.
// Each accepted input word's result word is registered and shown in the next cycle.
// Throughput: one word per cycle; the result register frees a slot every
// cycle in which its word is taken, so only output back-pressure stalls input.
// Reset (aresetn low, synchronous): parser returns to expecting a header,
// all accumulators clear, and the result register empties.
`timescale 1ns / 1ps

module tlv_record_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_end_of_buffer,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_kind,
    output logic [16:0] m_record_type,
    output logic [16:0] m_record_length,
    output logic [7:0]  m_value_byte,
    output logic        m_record_end,
    output logic [1:0]  m_error_code
);
    import tlvp_pkg::*;

    typedef logic [ValWidth-1:0] val_t;

    phase_t     phase_reg, phase_next;
    logic [1:0] type_mode_reg, type_mode_next;
    logic [1:0] length_mode_reg, length_mode_next;
    logic [3:0] length_nibble_reg, length_nibble_next;
    logic [7:0] high_byte_hold_reg, high_byte_hold_next;
    val_t       type_accum_reg, type_accum_next;
    val_t       length_accum_reg, length_accum_next;
    val_t       bytes_remaining_reg, bytes_remaining_next;

    logic       fire;
    logic       can_load;
    action_t    action;
    val_t       ext_one;
    val_t       ext_two;
    result_t    res_word;
    result_t    out_word;

    assign s_ready = can_load;
    assign fire    = s_valid && can_load;

    // Extension values for a one-byte and a two-byte escape.
    assign ext_one = {9'd0, s_data_byte} + val_t'(EscOne);
    assign ext_two = {1'b0, high_byte_hold_reg, s_data_byte} + TwoByteBias + val_t'(EscOne);

    // Decision and next state for the current input word.
    always_comb begin
        logic       do_start;
        logic       do_finish;
        logic [3:0] ln_cur;
        nclass_t    tc;
        nclass_t    lc;

        phase_next           = phase_reg;
        type_mode_next       = type_mode_reg;
        length_mode_next     = length_mode_reg;
        length_nibble_next   = length_nibble_reg;
        high_byte_hold_next  = high_byte_hold_reg;
        type_accum_next      = type_accum_reg;
        length_accum_next    = length_accum_reg;
        bytes_remaining_next = bytes_remaining_reg;
        action               = ACT_CONSUME;
        do_start             = 1'b0;
        do_finish            = 1'b0;
        ln_cur               = length_nibble_reg;
        tc                   = nibble_class(s_data_byte[3:0]);

        case (phase_reg)
            PH_TYPE_A: begin
                if (type_mode_reg == 2'(NC_ESC_ONE)) begin
                    type_accum_next = ext_one;
                    do_start        = 1'b1;
                end else if (s_end_of_buffer) begin
                    action = ACT_ERR_SHORT;
                end else begin
                    high_byte_hold_next = s_data_byte;
                    phase_next          = PH_TYPE_B;
                end
            end
            PH_TYPE_B: begin
                type_accum_next = ext_two;
                do_start        = 1'b1;
            end
            PH_LEN_A: begin
                if (length_mode_reg == 2'(NC_ESC_ONE)) begin
                    length_accum_next = ext_one;
                    do_finish         = 1'b1;
                end else if (s_end_of_buffer) begin
                    action = ACT_ERR_SHORT;
                end else begin
                    high_byte_hold_next = s_data_byte;
                    phase_next          = PH_LEN_B;
                end
            end
            PH_LEN_B: begin
                length_accum_next = ext_two;
                do_finish         = 1'b1;
            end
            PH_VALUE: begin
                if (bytes_remaining_reg <= val_t'(1)) begin
                    bytes_remaining_next = '0;
                    phase_next           = PH_HEADER;
                    action               = ACT_VALUE;
                end else if (s_end_of_buffer) begin
                    bytes_remaining_next = '0;
                    action               = ACT_ERR_SHORT;
                end else begin
                    bytes_remaining_next = bytes_remaining_reg - val_t'(1);
                    action               = ACT_VALUE;
                end
            end
            default: begin
                // Header byte; unused phase codes land here too.
                phase_next         = PH_HEADER;
                length_nibble_next = s_data_byte[7:4];
                ln_cur             = s_data_byte[7:4];
                if (tc == NC_RESERVED) begin
                    action = ACT_ERR_RSVD;
                end else if (tc == NC_LITERAL) begin
                    type_accum_next = {13'd0, s_data_byte[3:0]};
                    do_start        = 1'b1;
                end else if (s_end_of_buffer) begin
                    action = ACT_ERR_SHORT;
                end else begin
                    type_mode_next = 2'(tc);
                    phase_next     = PH_TYPE_A;
                end
            end
        endcase

        // Type is complete: look at the length nibble.
        lc = nibble_class(ln_cur);
        if (do_start) begin
            if (lc == NC_RESERVED) begin
                action = ACT_ERR_RSVD;
            end else if (lc == NC_LITERAL) begin
                length_accum_next = {13'd0, ln_cur};
                do_finish         = 1'b1;
            end else if (s_end_of_buffer) begin
                action = ACT_ERR_SHORT;
            end else begin
                length_mode_next = 2'(lc);
                phase_next       = PH_LEN_A;
            end
        end

        // Header is complete: descriptor, or a short buffer.
        if (do_finish) begin
            if (length_accum_next != '0 && s_end_of_buffer) begin
                action = ACT_ERR_SHORT;
            end else begin
                action               = ACT_DESC;
                bytes_remaining_next = length_accum_next;
                phase_next           = (length_accum_next == '0) ? PH_HEADER : PH_VALUE;
            end
        end

        if (action == ACT_ERR_SHORT || action == ACT_ERR_RSVD) begin
            phase_next = PH_HEADER;
        end
    end

    // Result word for the decided action.
    always_comb begin
        res_word = '0;
        case (action)
            ACT_CONSUME: begin
                res_word.kind = KIND_CONSUMED;
            end
            ACT_DESC: begin
                res_word.kind          = KIND_DESC;
                res_word.record_type   = type_accum_next;
                res_word.record_length = length_accum_next;
                res_word.record_end    = (length_accum_next == '0);
            end
            ACT_VALUE: begin
                res_word.kind       = KIND_VALUE;
                res_word.value_byte = s_data_byte;
                res_word.record_end = (phase_next == PH_HEADER);
            end
            ACT_ERR_SHORT: begin
                res_word.kind       = KIND_ERROR;
                res_word.error_code = ERR_INCOMPLETE;
            end
            ACT_ERR_RSVD: begin
                res_word.kind       = KIND_ERROR;
                res_word.error_code = ERR_RESERVED;
            end
            default: begin
                res_word = '0;
            end
        endcase
    end

    // Parser state advances only on an accepted word.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg           <= PH_HEADER;
            type_mode_reg       <= '0;
            length_mode_reg     <= '0;
            length_nibble_reg   <= '0;
            high_byte_hold_reg  <= '0;
            type_accum_reg      <= '0;
            length_accum_reg    <= '0;
            bytes_remaining_reg <= '0;
        end else if (fire) begin
            phase_reg           <= phase_next;
            type_mode_reg       <= type_mode_next;
            length_mode_reg     <= length_mode_next;
            length_nibble_reg   <= length_nibble_next;
            high_byte_hold_reg  <= high_byte_hold_next;
            type_accum_reg      <= type_accum_next;
            length_accum_reg    <= length_accum_next;
            bytes_remaining_reg <= bytes_remaining_next;
        end
    end

    tlvp_out_stage u_out_stage (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (fire),
        .load_word (res_word),
        .can_load  (can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (out_word)
    );

    assign m_kind          = out_word.kind;
    assign m_record_type   = out_word.record_type;
    assign m_record_length = out_word.record_length;
    assign m_value_byte    = out_word.value_byte;
    assign m_record_end    = out_word.record_end;
    assign m_error_code    = out_word.error_code;

endmodule

@@ src/tlvp_port_checker.sv @@
// Port-level checks for the TLV record parser, bound to the top level.
// Depends on tlvp_pkg for kind and error codes.
`timescale 1ns / 1ps

module tlvp_port_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_kind,
    input logic [16:0] m_record_length,
    input logic        m_record_end,
    input logic [1:0]  m_error_code
);
    import tlvp_pkg::*;

    // Every accepted word yields a result word in the next cycle.
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> m_valid)
        else $error("no result word after an accepted input word");

    // A stalled result word holds its kind.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_kind))
        else $error("stalled result word changed");

    // Error codes appear only on error words, and error words carry one.
    a_err_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind != KIND_ERROR |-> m_error_code == ERR_NONE)
        else $error("error code on a non-error word");

    a_err_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_ERROR |->
            m_error_code == ERR_INCOMPLETE || m_error_code == ERR_RESERVED)
        else $error("error word without a valid code");

    // A descriptor of zero length closes the record.
    a_empty_rec: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_kind == KIND_DESC && m_record_length == '0 |-> m_record_end)
        else $error("zero-length descriptor without record end");

endmodule

bind tlv_record_parser_unit tlvp_port_checker u_port_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_kind          (m_kind),
    .m_record_length (m_record_length),
    .m_record_end    (m_record_end),
    .m_error_code    (m_error_code)
);
